// ===== rtl/crc8d_pkg.sv =====
// package for the crc-8 packet deframer: types, codes, constants and the crc step
// used by the regs, parser and top level of the block; depends on nothing
`default_nettype none

package crc8d_pkg;

	localparam int BUF_DEPTH = 1024;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int LEN_W     = 11;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [7:0]       START_RST  = 8'd192;
	localparam logic [7:0]       KEY_RST    = 8'd140;
	localparam logic [LEN_W-1:0] MAXLEN_RST = 11'd1024;
	localparam logic [7:0]       CRC_SEED   = 8'h00;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_LEN  = 2'd1;
	localparam logic [1:0] ERR_HCRC = 2'd2;
	localparam logic [1:0] ERR_BCRC = 2'd3;

	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_KEY    = 2'd1;
	localparam logic [1:0] REG_MAXLEN = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_LENLO = 3'd2,
		PH_LENHI = 3'd3,
		PH_HCRC  = 3'd4,
		PH_DATA  = 3'd5,
		PH_BCRC  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0]       start_byte;
		logic [7:0]       crc_key;
		logic [LEN_W-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic             frame_ok;
		logic [1:0]       error_code;
		logic [7:0]       frame_type;
		logic [LEN_W-1:0] frame_length;
	} parse_res_t;

	typedef struct packed {
		logic              we;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} buf_wr_t;

	// reflected crc-8, one byte, lsb first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] key,
			input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ key;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crc8d_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module crc8d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crc8d_regs.sv =====
// apb-style configuration registers: start byte, crc key, max length
// depends on crc8d_pkg
`default_nettype none

module crc8d_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [crc8d_pkg::ADDR_W-1:0] paddr,
	input  wire logic [crc8d_pkg::DATA_W-1:0] pwdata,
	output logic      [crc8d_pkg::DATA_W-1:0] prdata,
	output crc8d_pkg::cfg_t                  cfg
);
	import crc8d_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_RST;
			cfg_q.crc_key    <= KEY_RST;
			cfg_q.max_length <= MAXLEN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START:  cfg_q.start_byte <= pwdata[7:0];
				REG_KEY:    cfg_q.crc_key    <= pwdata[7:0];
				REG_MAXLEN: cfg_q.max_length <= pwdata[LEN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START:  prdata = {24'd0, cfg_q.start_byte};
			REG_KEY:    prdata = {24'd0, cfg_q.crc_key};
			REG_MAXLEN: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.max_length};
			default:    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/crc8d_parser.sv =====
// frame parser: phase machine, header and body crc, payload write requests
// depends on crc8d_pkg
`default_nettype none

module crc8d_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    byte_in,
	input  wire crc8d_pkg::cfg_t cfg,
	output crc8d_pkg::parse_res_t res,
	output crc8d_pkg::buf_wr_t    wr
);
	import crc8d_pkg::*;

	phase_t           phase_q, phase_d;
	logic [7:0]       type_q, type_d;
	logic [LEN_W-1:0] length_q, length_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [7:0]       crc_q, crc_d;
	logic [7:0]       crc_next;
	logic [15:0]      full_len;
	logic [LEN_W-1:0] count_inc;
	logic             ok;
	logic [1:0]       err;

	// the type byte restarts the crc from the seed
	assign crc_next  = crc8_step((phase_q == PH_TYPE) ? CRC_SEED : crc_q, cfg.crc_key, byte_in);
	assign full_len  = {byte_in, count_q[7:0]};
	assign count_inc = count_q + LEN_W'(1);

	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		length_d = length_q;
		count_d  = count_q;
		crc_d    = crc_q;
		if (step) begin
			case (phase_q)
				PH_TYPE: begin
					type_d  = byte_in;
					crc_d   = crc_next;
					phase_d = PH_LENLO;
				end
				PH_LENLO: begin
					count_d = {3'd0, byte_in};
					crc_d   = crc_next;
					phase_d = PH_LENHI;
				end
				PH_LENHI: begin
					if (full_len > {5'd0, cfg.max_length}) begin
						phase_d = PH_IDLE;
					end else begin
						length_d = full_len[LEN_W-1:0];
						count_d  = '0;
						crc_d    = crc_next;
						phase_d  = PH_HCRC;
					end
				end
				PH_HCRC: begin
					if (crc_q == byte_in) begin
						phase_d = (length_q != '0) ? PH_DATA : PH_BCRC;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_DATA: begin
					crc_d   = crc_next;
					count_d = count_inc;
					if (count_inc >= length_q) begin
						phase_d = PH_BCRC;
					end
				end
				PH_BCRC: begin
					phase_d = PH_IDLE;
				end
				default: begin
					// idle and the unused code both hunt for the start byte
					phase_d = (byte_in == cfg.start_byte) ? PH_TYPE : PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ok      = 1'b0;
		err     = ERR_NONE;
		wr.we   = 1'b0;
		wr.addr = count_q[BUF_AW-1:0];
		wr.data = byte_in;
		if (step) begin
			case (phase_q)
				PH_LENHI: begin
					if (full_len > {5'd0, cfg.max_length}) begin
						err = ERR_LEN;
					end
				end
				PH_HCRC: begin
					if (crc_q != byte_in) begin
						err = ERR_HCRC;
					end
				end
				PH_DATA: begin
					// bytes past the end of the buffer still feed the crc
					wr.we = (32'(count_q) < BUF_DEPTH);
				end
				PH_BCRC: begin
					if (crc_q == byte_in) begin
						ok = 1'b1;
					end else begin
						err = ERR_BCRC;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.frame_ok     = ok;
	assign res.error_code   = err;
	assign res.frame_type   = type_d;
	assign res.frame_length = length_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			type_q   <= '0;
			length_q <= '0;
			count_q  <= '0;
			crc_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			length_q <= length_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/crc8_packet_deframer_core.sv =====
// top level of the crc-8 packet deframer: input handshake, result register, payload buffer
// depends on crc8d_pkg, crc8d_regs, crc8d_parser and crc8d_ram
//
// usage:
//   input channel (in_valid/in_ready) carries cmd, byte_in and read_index. cmd push feeds
//   one received byte to the frame parser; cmd read fetches a stored payload byte.
//   output channel (out_valid/out_ready) returns exactly one result item per input item,
//   in order: frame_ok, error_code, frame_type, frame_length and read_data.
//   an accepted item's result is registered and shown in the next cycle; unless stalled,
//   throughput is one item per cycle; the parser update is one unrolled crc-8 byte step
//   and the buffer is a single ram with one write and one registered read port.
//   in_ready is high whenever the result register is empty or being taken, so a new
//   item enters in the same cycle the previous result leaves.
//   when the receiver stalls, the result register and the ram read data hold, and
//   in_ready falls until the result is taken.
//   reset clears the parser to hunting, type and length to zero, the configuration to
//   start byte 192, key 140, max length 1024; buffer contents are undefined until written.
//   configuration registers sit at paddr 0, 4 and 8; pready is always high.
`default_nettype none

module crc8_packet_deframer_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cmd,
	input  wire logic [7:0]                        byte_in,
	input  wire logic [9:0]                        read_index,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   frame_ok,
	output logic      [1:0]                        error_code,
	output logic      [7:0]                        frame_type,
	output logic      [crc8d_pkg::LEN_W-1:0]       frame_length,
	output logic      [7:0]                        read_data,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [crc8d_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [crc8d_pkg::DATA_W-1:0]      pwdata,
	output logic      [crc8d_pkg::DATA_W-1:0]      prdata,
	output logic                                   pready
);
	import crc8d_pkg::*;

	cfg_t             cfg;
	parse_res_t       res;
	buf_wr_t          wr;
	logic             accept;
	logic             step;
	logic             rd_req;
	logic [7:0]       ram_rdata;
	logic             out_valid_q;
	logic             rd_q;
	logic             ok_q;
	logic [1:0]       err_q;
	logic [7:0]       type_q;
	logic [LEN_W-1:0] len_q;

	assign pready   = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign step     = accept && (cmd == CMD_PUSH);
	assign rd_req   = accept && (cmd == CMD_READ) && (32'(read_index) < BUF_DEPTH);

	crc8d_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	crc8d_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_in),
		.cfg     (cfg),
		.res     (res),
		.wr      (wr)
	);

	crc8d_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_req),
		.raddr (read_index[BUF_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// ram read data only moves on a read item, so it holds through a stall
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= rd_req;
			ok_q   <= res.frame_ok;
			err_q  <= res.error_code;
			type_q <= res.frame_type;
			len_q  <= res.frame_length;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_ok     = ok_q;
	assign error_code   = err_q;
	assign frame_type   = type_q;
	assign frame_length = len_q;
	assign read_data    = rd_q ? ram_rdata : 8'd0;

`ifndef SYNTHESIS
	a_ok_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_ok && (error_code != ERR_NONE)))
		else $error("frame_ok raised together with an error code");

	a_read_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_READ)) |=> (!frame_ok && (error_code == ERR_NONE)))
		else $error("read item carries frame status");

	a_push_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_PUSH)) |=> (read_data == 8'd0))
		else $error("byte item returned nonzero read data");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> step)
		else $error("buffer written without a byte item");
`endif

endmodule

`default_nettype wire

// ===== tb/crc8_deframer_checker.sv =====
// checker for the crc-8 packet deframer: watches the item channels and the config port,
// predicts each result from its own copy of the parser state and compares in order
// depends on crc8d_pkg
module crc8_deframer_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             cmd,
	input  logic [7:0]                       byte_in,
	input  logic [9:0]                       read_index,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             frame_ok,
	input  logic [1:0]                       error_code,
	input  logic [7:0]                       frame_type,
	input  logic [crc8d_pkg::LEN_W-1:0]      frame_length,
	input  logic [7:0]                       read_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [crc8d_pkg::ADDR_W-1:0]     paddr,
	input  logic [crc8d_pkg::DATA_W-1:0]     pwdata,
	output int                               fault_count,
	output int                               pending,
	output logic [crc8d_pkg::BUF_DEPTH-1:0]  stored_mask,
	output logic                             hunting
);
	timeunit 1ns;
	timeprecision 1ps;
	import crc8d_pkg::*;

	typedef struct packed {
		logic             ok;
		logic [1:0]       err;
		logic [7:0]       ftype;
		logic [LEN_W-1:0] flen;
		logic [7:0]       rdata;
	} frame_result_t;

	frame_result_t expected_results[$];

	logic [7:0]       start_q;
	logic [7:0]       key_q;
	logic [LEN_W-1:0] maxlen_q;

	phase_t           parse_phase;
	logic [7:0]       type_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] count_q;
	logic [7:0]       crc_q;
	logic [7:0]       payload_mem [BUF_DEPTH];

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ({1'b0, c[7:1]} ^ key_q) : {1'b0, c[7:1]};
		end
		return c;
	endfunction

	function automatic frame_result_t deframe_step(input logic c, input logic [7:0] b,
			input logic [9:0] idx);
		frame_result_t r;
		logic [15:0] full_len;
		r = '0;
		if (c == CMD_READ) begin
			r.rdata = payload_mem[idx];
		end else begin
			case (parse_phase)
				PH_TYPE: begin
					type_q = b;
					crc_q = crc_byte(CRC_SEED, b);
					parse_phase = PH_LENLO;
				end
				PH_LENLO: begin
					// low length byte parks in the counter until the high byte arrives
					count_q = {3'b000, b};
					crc_q = crc_byte(crc_q, b);
					parse_phase = PH_LENHI;
				end
				PH_LENHI: begin
					full_len = {b, count_q[7:0]};
					if (full_len > {5'b00000, maxlen_q}) begin
						r.err = ERR_LEN;
						parse_phase = PH_IDLE;
					end else begin
						length_q = full_len[LEN_W-1:0];
						count_q = '0;
						crc_q = crc_byte(crc_q, b);
						parse_phase = PH_HCRC;
					end
				end
				PH_HCRC: begin
					if (crc_q != b) begin
						r.err = ERR_HCRC;
						parse_phase = PH_IDLE;
					end else if (length_q != '0) begin
						parse_phase = PH_DATA;
					end else begin
						parse_phase = PH_BCRC;
					end
				end
				PH_DATA: begin
					// bytes past the end of the buffer still feed the crc
					if (count_q < BUF_DEPTH) begin
						payload_mem[count_q[BUF_AW-1:0]] = b;
						stored_mask[count_q[BUF_AW-1:0]] = 1'b1;
					end
					crc_q = crc_byte(crc_q, b);
					count_q = count_q + LEN_W'(1);
					if (count_q >= length_q) begin
						parse_phase = PH_BCRC;
					end
				end
				PH_BCRC: begin
					parse_phase = PH_IDLE;
					if (crc_q == b) begin
						r.ok = 1'b1;
					end else begin
						r.err = ERR_BCRC;
					end
				end
				default: begin
					if (b == start_q) begin
						parse_phase = PH_TYPE;
					end else begin
						parse_phase = PH_IDLE;
					end
				end
			endcase
		end
		r.ftype = type_q;
		r.flen = length_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t got;
		frame_result_t want;
		if (!arst_n) begin
			start_q = START_RST;
			key_q = KEY_RST;
			maxlen_q = MAXLEN_RST;
			parse_phase = PH_IDLE;
			type_q = '0;
			length_q = '0;
			count_q = '0;
			crc_q = CRC_SEED;
			stored_mask = '0;
			fault_count = 0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("checker: result with no item outstanding");
					end
				end else begin
					want = expected_results.pop_front();
					got = {frame_ok, error_code, frame_type, frame_length, read_data};
					if (got !== want) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("checker: expected ok %0d err %0d type %02h len %0d data %02h",
								want.ok, want.err, want.ftype, want.flen, want.rdata);
							$display("checker: got      ok %0d err %0d type %02h len %0d data %02h",
								got.ok, got.err, got.ftype, got.flen, got.rdata);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(deframe_step(cmd, byte_in, read_index));
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_START:  start_q = pwdata[7:0];
					REG_KEY:    key_q = pwdata[7:0];
					REG_MAXLEN: maxlen_q = pwdata[LEN_W-1:0];
					default: ;
				endcase
			end
		end
		pending = expected_results.size();
		hunting = (parse_phase == PH_IDLE);
	end

endmodule

// ===== tb/tb_crc8_packet_deframer_core.sv =====
// testbench top for crc8_packet_deframer_core: clock, reset, frame stimulus, config writes
// and the verdict; prediction and comparison live in crc8_deframer_checker
// depends on crc8d_pkg, crc8_deframer_checker and the rtl
module tb_crc8_packet_deframer_core;
	timeunit 1ns;
	timeprecision 1ps;
	import crc8d_pkg::*;

	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SEG_ITEMS   = 25;
	localparam logic [1:0] REG_UNUSED  = 2'd3;

	typedef enum {FLAW_NONE, FLAW_HDR, FLAW_BODY, FLAW_CUT} flaw_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  cmd = CMD_PUSH;
	logic [7:0]            byte_in = '0;
	logic [9:0]            read_index = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  frame_ok;
	logic [1:0]            error_code;
	logic [7:0]            frame_type;
	logic [LEN_W-1:0]      frame_length;
	logic [7:0]            read_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [DATA_W-1:0]     pwdata = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	int                    fault_count;
	int                    pending;
	logic [BUF_DEPTH-1:0]  stored_mask;
	logic                  hunting;

	logic [7:0]       start_sel;
	logic [7:0]       key_sel;
	logic [LEN_W-1:0] maxlen_sel;
	int               gap_pct;
	int               stall_pct;
	int               read_mix_pct;
	int               items_sent;
	int               cycle_count = 0;

	crc8_packet_deframer_core u_top (.*);
	crc8_deframer_checker u_chk (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		r = crc ^ data;
		repeat (8) r = (r >> 1) ^ (r[0] ? key_sel : 8'h00);
		return r;
	endfunction

	task automatic send_item(input logic c, input logic [7:0] b, input logic [9:0] idx);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		in_valid <= 1'b1;
		cmd <= c;
		byte_in <= b;
		read_index <= idx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		send_item(CMD_PUSH, b, 10'($urandom));
	endtask

	task automatic read_entry(input logic [9:0] idx);
		send_item(CMD_READ, 8'($urandom), idx);
	endtask

	// only entries the parser has already filled are read
	task automatic read_any();
		logic [9:0] idx;
		for (int tries = 0; tries < 16; tries++) begin
			idx = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 63)) : 10'($urandom);
			if (stored_mask[idx]) begin
				read_entry(idx);
				return;
			end
		end
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
			input flaw_t flaw);
		logic [7:0] crc;
		logic [7:0] b;
		int cut_at;
		cut_at = (flaw == FLAW_CUT) ? $urandom_range(0, flen) : -1;
		crc = CRC_SEED;
		push_byte(start_sel);
		push_byte(ftype);
		crc = crc8_next(crc, ftype);
		push_byte(flen[7:0]);
		crc = crc8_next(crc, flen[7:0]);
		push_byte(flen[15:8]);
		if (flen > maxlen_sel) begin
			return;
		end
		crc = crc8_next(crc, flen[15:8]);
		if (flaw == FLAW_HDR) begin
			push_byte(crc ^ 8'($urandom_range(1, 255)));
			return;
		end
		push_byte(crc);
		for (int i = 0; i < flen; i++) begin
			if (i == cut_at) begin
				return;
			end
			if ($urandom_range(0, 99) < read_mix_pct) begin
				read_any();
			end
			b = 8'($urandom);
			push_byte(b);
			crc = crc8_next(crc, b);
		end
		if (flaw == FLAW_CUT) begin
			return;
		end
		push_byte((flaw == FLAW_BODY) ? (crc ^ 8'($urandom_range(1, 255))) : crc);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] sb, input logic [7:0] key,
			input logic [LEN_W-1:0] maxlen);
		write_reg(REG_START, DATA_W'(sb));
		write_reg(REG_KEY, DATA_W'(key));
		write_reg(REG_MAXLEN, DATA_W'(maxlen));
		start_sel = sb;
		key_sel = key;
		maxlen_sel = maxlen;
	endtask

	// drop valid, then wait until every outstanding result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_traffic(input int count);
		int stop_at;
		int pick;
		int r;
		int cap;
		logic [15:0] flen;
		flaw_t flaw;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				r = $urandom_range(0, 99);
				cap = (maxlen_sel < 64) ? int'(maxlen_sel) : 64;
				if (r < 75) begin
					flen = 16'($urandom_range(0, (cap < 12) ? cap : 12));
				end else if (r < 82) begin
					flen = 16'($urandom_range(0, cap));
				end else if (r < 90) begin
					flen = (maxlen_sel <= 64) ? 16'(maxlen_sel) : 16'($urandom_range(0, cap));
				end else if (r < 95) begin
					flen = 16'(maxlen_sel + 1 + $urandom_range(0, 2));
				end else begin
					flen = 16'($urandom_range(maxlen_sel + 1, 65535));
				end
				r = $urandom_range(0, 99);
				if (r < 80) begin
					flaw = FLAW_NONE;
				end else if (r < 87) begin
					flaw = FLAW_HDR;
				end else if (r < 94) begin
					flaw = FLAW_BODY;
				end else begin
					flaw = FLAW_CUT;
				end
				send_frame(8'($urandom), flen, flaw);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 3)) read_any();
			end else begin
				// broken sequences: stray bytes, sometimes a lone start byte
				repeat ($urandom_range(1, 4)) begin
					push_byte(($urandom_range(0, 3) == 0) ? start_sel : 8'($urandom));
				end
			end
		end
	endtask

	initial begin
		logic [7:0] sb;
		logic [7:0] key;
		logic [LEN_W-1:0] maxlen;
		start_sel = START_RST;
		key_sel = KEY_RST;
		maxlen_sel = MAXLEN_RST;
		gap_pct = 20;
		stall_pct = 64;
		read_mix_pct = 0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset configuration
		send_frame(8'hFF, 16'd2, FLAW_NONE);
		read_entry(10'd0);
		read_entry(10'd1);
		send_frame(8'h00, 16'd0, FLAW_BODY);
		send_frame(8'h5A, 16'd1, FLAW_HDR);
		send_frame(8'hA5, 16'hFFFF, FLAW_NONE);

		read_mix_pct = 10;
		for (int seg = 0; seg < 6; seg++) begin
			settle();
			if (seg < 2) begin
				gap_pct = 20;
				stall_pct = 64;
			end else if (seg < 4) begin
				gap_pct = 64;
				stall_pct = 20;
			end else begin
				gap_pct = 0;
				stall_pct = 0;
			end
			case (seg)
				0: begin
					sb = 8'h7E;
					key = 8'hE0;
					maxlen = 11'd40;
				end
				1: begin
					sb = 8'h00;
					key = 8'h00;
					maxlen = 11'd0;
				end
				2: begin
					sb = 8'hFF;
					key = 8'hFF;
					maxlen = 11'd2047;
				end
				3: begin
					sb = 8'($urandom);
					key = 8'($urandom);
					maxlen = 11'($urandom_range(1, 64));
				end
				4: begin
					sb = 8'h55;
					key = 8'hB8;
					maxlen = 11'd1024;
				end
				default: begin
					sb = 8'($urandom);
					key = 8'($urandom);
					maxlen = 11'($urandom_range(0, 2047));
				end
			endcase
			configure(sb, key, maxlen);
			if (seg == 0) begin
				write_reg(REG_UNUSED, $urandom);
			end
			if (seg == 2) begin
				// one frame longer than the buffer, started from the hunting state
				while (!hunting) push_byte(~start_sel);
				read_mix_pct = 0;
				send_frame(8'($urandom), 16'd1030, FLAW_NONE);
				read_mix_pct = 10;
			end
			random_traffic(SEG_ITEMS);
		end
		settle();

		if (fault_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
